@@ rtl/core/uint_to_ascii_formatter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned-to-ASCII formatter.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef UINT_TO_ASCII_FORMATTER_DEFINES_SVH
`define UINT_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define UAF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define UAF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UAF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define UAF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/uaf_pkg.sv @@
// ----------------------------------------------------------------------------
// uaf_pkg: shared types and constants of the formatter
// Character constants, digit tables, controller states and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package uaf_pkg;

    // Field widths.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 4;

    // Text layout.
    localparam int DEC_DIGITS  = 10;
    localparam int HEX_NIBBLES = 8;
    localparam int HEX_TOP     = 28;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X    = 8'h78;

    // ASCII of the sixteen hexadecimal digits, uppercase.
    localparam logic [CHAR_W-1:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // One row holds k * 10^e for k = 1..9, at index k - 1. Widened to 34 bits
    // since 9 * 10^9 does not fit in 32.
    localparam int MULT_W = 34;
    typedef logic [8:0][MULT_W-1:0] dec_row_t;

    function automatic dec_row_t dec_row(input int unsigned e);
        dec_row_t          row;
        logic [MULT_W-1:0] p;
        p = MULT_W'(1);
        for (int unsigned i = 0; i < e; i++)
        begin
            p = p * MULT_W'(10);
        end
        for (int unsigned k = 1; k <= 9; k++)
        begin
            row[k-1] = p * MULT_W'(k);
        end
        return row;
    endfunction

    localparam dec_row_t DEC_ROWS [DEC_DIGITS] = '{
        dec_row(0), dec_row(1), dec_row(2), dec_row(3), dec_row(4),
        dec_row(5), dec_row(6), dec_row(7), dec_row(8), dec_row(9)
    };

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEX_ZERO,
        ST_HEX_X,
        ST_HEX_DIG,
        ST_DEC_CMP,
        ST_DEC_EMIT
    } ctl_state_t;

    // Source of the next output character.
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_X,
        OUT_HEX,
        OUT_DEC
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 hex_shift;
        logic                 dec_cmp;
        logic                 dec_step;
        logic                 out_load;
        out_sel_t             out_sel;
        logic                 out_last;
        logic [CNT_W-1:0]     pos;
    } uaf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic digit_zero;
    } uaf_sts_t;

endpackage

@@ rtl/core/uaf_datapath.sv @@
// ----------------------------------------------------------------------------
// uaf_datapath: value register, decimal digit unit and output register
// Holds the value being rendered, finds one decimal digit per compare step,
// shifts out hex nibbles and keeps the registered output beat.
// ----------------------------------------------------------------------------
`include "uint_to_ascii_formatter_defines.svh"

module uaf_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  uaf_pkg::uaf_cmd_t              cmd,
    output uaf_pkg::uaf_sts_t              sts,
    input  logic [uaf_pkg::VALUE_W-1:0]    value_in,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [uaf_pkg::CHAR_W-1:0]     m_axis_tdata,
    output logic                           m_axis_tlast
);

    logic [uaf_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [uaf_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic [uaf_pkg::VALUE_W-1:0] sub_reg, sub_next;
    logic                        out_valid_reg, out_valid_next;
    logic [uaf_pkg::CHAR_W-1:0]  out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_free;
    uaf_pkg::dec_row_t           row;

    // Digit search: count how many multiples of the current power of ten
    // fit in the remainder; the largest one that fits is subtracted later.
    always_comb
    begin
        row        = uaf_pkg::DEC_ROWS[cmd.pos];
        digit_next = '0;
        sub_next   = '0;
        for (int i = 0; i < 9; i++)
        begin
            if ({2'b00, val_reg} >= row[i])
            begin
                digit_next = uaf_pkg::DIGIT_W'(i + 1);
                sub_next   = row[i][uaf_pkg::VALUE_W-1:0];
            end
        end
    end

    // Value register: load, hex shift or decimal subtract.
    always_comb
    begin
        val_next = val_reg;
        if (cmd.load)
        begin
            val_next = value_in;
        end
        else if (cmd.hex_shift)
        begin
            val_next = {val_reg[uaf_pkg::VALUE_W-5:0], 4'h0};
        end
        else if (cmd.dec_step)
        begin
            val_next = val_reg - sub_reg;
        end
    end

    // Output character selection.
    always_comb
    begin
        unique case (cmd.out_sel)
            uaf_pkg::OUT_ZERO: out_data_next = uaf_pkg::CHAR_ZERO;
            uaf_pkg::OUT_X:    out_data_next = uaf_pkg::CHAR_X;
            uaf_pkg::OUT_HEX:  out_data_next = uaf_pkg::HEX_CHARS[val_reg[uaf_pkg::HEX_TOP +: 4]];
            uaf_pkg::OUT_DEC:  out_data_next = uaf_pkg::HEX_CHARS[digit_reg];
            default:           out_data_next = uaf_pkg::CHAR_ZERO;
        endcase
    end

    // Output register: a new beat may enter once the held one is taken.
    assign out_free       = !out_valid_reg || m_axis_tready;
    assign out_valid_next = cmd.out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    assign out_last_next  = cmd.out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        if (cmd.dec_cmp)
        begin
            digit_reg <= digit_next;
            sub_reg   <= sub_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign sts.out_free   = out_free;
    assign sts.digit_zero = (digit_reg == '0);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // A beat is never written over one that is still waiting.
    `UAF_ASSERT_IMP(a_load_when_free, clk, rst_n, cmd.out_load, out_free, "output beat overwritten")
    // The remainder shrinks only as its digit goes out.
    `UAF_ASSERT_IMP(a_step_with_emit, clk, rst_n, cmd.dec_step, cmd.out_load && cmd.out_sel == uaf_pkg::OUT_DEC, "decimal step without emitted digit")
    // A nibble is shifted away only as it is emitted.
    `UAF_ASSERT_IMP(a_shift_with_emit, clk, rst_n, cmd.hex_shift, cmd.out_load && cmd.out_sel == uaf_pkg::OUT_HEX, "hex shift without emitted nibble")
    // A loaded beat is valid on the next cycle.
    `UAF_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.out_load, out_valid_reg, "loaded beat not presented")

endmodule

@@ rtl/core/uaf_ctrl.sv @@
// ----------------------------------------------------------------------------
// uaf_ctrl: formatter sequencer
// Accepts one input beat, then steps through the prefix and hex digits or
// through the ten decimal positions, issuing datapath commands.
// ----------------------------------------------------------------------------
module uaf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_hex,
    output uaf_pkg::uaf_cmd_t   cmd,
    input  uaf_pkg::uaf_sts_t   sts
);

    uaf_pkg::ctl_state_t          state_reg, state_next;
    logic [uaf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         started_reg, started_next;

    // State, position counter and leading-zero flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= uaf_pkg::ST_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.out_sel  = uaf_pkg::OUT_ZERO;
        cmd.pos      = cnt_reg;

        unique case (state_reg)
            uaf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    started_next = 1'b0;
                    cnt_next     = uaf_pkg::CNT_W'(uaf_pkg::DEC_DIGITS - 1);
                    state_next   = in_hex ? uaf_pkg::ST_HEX_ZERO : uaf_pkg::ST_DEC_CMP;
                end
            end

            uaf_pkg::ST_HEX_ZERO:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = uaf_pkg::OUT_ZERO;
                    state_next   = uaf_pkg::ST_HEX_X;
                end
            end

            uaf_pkg::ST_HEX_X:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = uaf_pkg::OUT_X;
                    cnt_next     = uaf_pkg::CNT_W'(uaf_pkg::HEX_NIBBLES - 1);
                    state_next   = uaf_pkg::ST_HEX_DIG;
                end
            end

            uaf_pkg::ST_HEX_DIG:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = uaf_pkg::OUT_HEX;
                    cmd.hex_shift = 1'b1;
                    cmd.out_last  = (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        state_next = uaf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end

            uaf_pkg::ST_DEC_CMP:
            begin
                cmd.dec_cmp = 1'b1;
                state_next  = uaf_pkg::ST_DEC_EMIT;
            end

            uaf_pkg::ST_DEC_EMIT:
            begin
                // Leading zeros are dropped, but the units digit always goes out.
                if (!started_reg && sts.digit_zero && cnt_reg != '0)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = uaf_pkg::ST_DEC_CMP;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = uaf_pkg::OUT_DEC;
                    cmd.dec_step = 1'b1;
                    cmd.out_last = (cnt_reg == '0);
                    started_next = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = uaf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = uaf_pkg::ST_DEC_CMP;
                    end
                end
            end

            default:
            begin
                state_next = uaf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/uint_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// uint_to_ascii_formatter: 32-bit unsigned value to ASCII text
// Channel   Dir  Fields (low bit up)            Beat
// s_axis    in   tuser: op; tdata: value[31:0]  one value to render
// m_axis    out  tdata: char_code; tlast: last  one character
//
// A hex value is accepted, then the prefix 0x and eight hex digits go out.
// A decimal value is accepted, then a compare step and an emit step run for
// each of the ten decimal positions through the shared subtractor; skipped
// leading zeros cost the same as emitted digits.
// Output stalls hold the sequencer; the next value is taken while the last
// character still waits in the output register. Reset clears all control.
// ----------------------------------------------------------------------------
module uint_to_ascii_formatter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [uaf_pkg::VALUE_W-1:0]   s_axis_tdata,   // value[31:0]
    input  logic                          s_axis_tuser,   // op (1 = hex)
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [uaf_pkg::CHAR_W-1:0]    m_axis_tdata,   // char_code[7:0]
    output logic                          m_axis_tlast
);

    uaf_pkg::uaf_cmd_t cmd;
    uaf_pkg::uaf_sts_t sts;

    // Sequencer.
    uaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_hex   (s_axis_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Value, digit unit and output register.
    uaf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .value_in      (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
